@@ rtl/dcir_pkg.sv @@
// Package for the DNA context counter with inverted repeats.
// Holds symbol codes, byte constants, command and state types and the
// symbol decode and complement functions. No dependencies.
package dcir_pkg;

    localparam int SYM_BITS        = 3;
    localparam int NUM_SYMS        = 5;
    localparam int OUT_BITS        = 16;
    localparam int CTX_MAX_SYMBOLS = 8;
    localparam int CTX_MAX_BITS    = SYM_BITS * CTX_MAX_SYMBOLS;
    localparam int CFG_INDEX_BITS  = 2;

    typedef logic [SYM_BITS-1:0]     sym_t;
    typedef logic [CTX_MAX_BITS-1:0] ctx_t;

    localparam sym_t SYM_A = 3'd0;
    localparam sym_t SYM_C = 3'd1;
    localparam sym_t SYM_T = 3'd2;
    localparam sym_t SYM_G = 3'd3;
    localparam sym_t SYM_N = 3'd4;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_N = 8'h4E;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_REPEAT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SKIP_LEADING = 2'd1;

    typedef struct packed {
        logic ok;
        sym_t sym;
    } decode_t;

    typedef struct packed {
        logic count;
        ctx_t fwd_ctx;
        sym_t fwd_sym;
        logic inv_en;
        ctx_t inv_ctx;
        sym_t inv_sym;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD,
        ST_INV_RD,
        ST_INV_WR,
        ST_EMIT
    } back_state_t;

    function automatic decode_t decode_byte(input logic [7:0] b);
        decode_t d;
        d.ok  = 1'b1;
        d.sym = SYM_A;
        unique case (b)
            CHAR_A:  d.sym = SYM_A;
            CHAR_C:  d.sym = SYM_C;
            CHAR_T:  d.sym = SYM_T;
            CHAR_G:  d.sym = SYM_G;
            CHAR_N:  d.sym = SYM_N;
            default: d.ok  = 1'b0;
        endcase
        return d;
    endfunction

    function automatic sym_t comp_sym(input sym_t s);
        sym_t r;
        r = s;
        unique case (s)
            SYM_A:   r = SYM_T;
            SYM_C:   r = SYM_G;
            SYM_T:   r = SYM_A;
            SYM_G:   r = SYM_C;
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/dcir_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module dcir_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_array[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dcir_front.sv @@
// Front end: configuration registers, symbol history and leading skip.
// Classifies each item into a counter command. Uses dcir_pkg.
module dcir_front #(
    parameter int CONTEXT_SYMBOLS = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [dcir_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic                                   cfg_data,
    input  logic                                   accept,
    input  logic                                   opcode,
    input  logic [7:0]                             symbol_byte,
    input  logic [11:0]                            query_context,
    output dcir_pkg::cmd_t                         cmd
);

    import dcir_pkg::*;

    localparam int CTX_BITS  = SYM_BITS * CONTEXT_SYMBOLS;
    localparam int SKIP_BITS = $clog2(CONTEXT_SYMBOLS + 1);

    logic                 inv_repeat_reg;
    logic                 skip_leading_reg;
    logic [CTX_BITS-1:0]  history_reg;
    logic [CTX_BITS-1:0]  history_next;
    logic [SKIP_BITS-1:0] skip_cnt_reg;
    logic [SKIP_BITS-1:0] skip_cnt_next;
    logic                 skipping;
    decode_t              dec;
    logic [CTX_BITS-1:0]  inv_ctx;
    ctx_t                 query_wide;

    assign skipping   = skip_leading_reg && (skip_cnt_reg < SKIP_BITS'(CONTEXT_SYMBOLS));
    assign dec        = decode_byte(symbol_byte);
    assign query_wide = CTX_MAX_BITS'(query_context);

    always_comb
    begin
        inv_ctx = '0;
        inv_ctx[SYM_BITS*(CONTEXT_SYMBOLS-1) +: SYM_BITS] = comp_sym(dec.sym);
        for (int j = 0; j < CONTEXT_SYMBOLS - 1; j++)
        begin
            inv_ctx[SYM_BITS*j +: SYM_BITS] =
                comp_sym(history_reg[SYM_BITS*(CONTEXT_SYMBOLS-2-j) +: SYM_BITS]);
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.fwd_ctx = CTX_MAX_BITS'(history_reg);
        cmd.fwd_sym = dec.sym;
        cmd.inv_ctx = CTX_MAX_BITS'(inv_ctx);
        cmd.inv_sym = comp_sym(history_reg[SYM_BITS*(CONTEXT_SYMBOLS-1) +: SYM_BITS]);
        if (opcode == OP_READ)
        begin
            cmd.fwd_ctx                 = '0;
            cmd.fwd_ctx[CTX_BITS-1:0]   = query_wide[CTX_BITS-1:0];
        end
        else if (!skipping && dec.ok)
        begin
            cmd.count  = 1'b1;
            cmd.inv_en = inv_repeat_reg;
        end
    end

    always_comb
    begin
        history_next  = history_reg;
        skip_cnt_next = skip_cnt_reg;
        if (accept && opcode == OP_COUNT)
        begin
            if (skipping)
            begin
                skip_cnt_next = skip_cnt_reg + 1'b1;
            end
            else if (dec.ok)
            begin
                history_next = CTX_BITS'({history_reg, dec.sym});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_repeat_reg   <= 1'b0;
            skip_leading_reg <= 1'b0;
            history_reg      <= '0;
            skip_cnt_reg     <= '0;
        end
        else
        begin
            history_reg  <= history_next;
            skip_cnt_reg <= skip_cnt_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_INV_REPEAT:   inv_repeat_reg   <= cfg_data;
                    CFG_SKIP_LEADING: skip_leading_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

endmodule

@@ rtl/dcir_queue.sv @@
// Short command queue between front end and counter back end.
// Uses dcir_pkg.
module dcir_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dcir_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output dcir_pkg::cmd_t cmd_out,
    output logic           empty
);

    import dcir_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    cmd_t                slot_array [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (fill_reg == CNT_BITS'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = slot_array[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_array[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= advance(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= advance(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/dcir_back.sv @@
// Back end: read-modify-write sequencer on the counter RAM, clearing pass
// after reset and the output register. Uses dcir_pkg and dcir_ram.
module dcir_back #(
    parameter int CONTEXT_SYMBOLS = 4,
    parameter int COUNT_BITS      = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  dcir_pkg::cmd_t                    q_cmd,
    output logic                              q_pop,
    output logic                              clearing,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dcir_pkg::OUT_BITS-1:0]     count_a,
    output logic [dcir_pkg::OUT_BITS-1:0]     count_c,
    output logic [dcir_pkg::OUT_BITS-1:0]     count_t,
    output logic [dcir_pkg::OUT_BITS-1:0]     count_g,
    output logic [dcir_pkg::OUT_BITS-1:0]     count_n,
    output logic                              symbol_accepted
);

    import dcir_pkg::*;

    localparam int CTX_BITS  = SYM_BITS * CONTEXT_SYMBOLS;
    localparam int ROW_BITS  = NUM_SYMS * COUNT_BITS;
    localparam int RAM_DEPTH = 1 << CTX_BITS;

    typedef logic [NUM_SYMS-1:0][COUNT_BITS-1:0] row_t;
    typedef logic [NUM_SYMS-1:0][OUT_BITS-1:0]   out_row_t;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [CTX_BITS-1:0]  clr_addr_reg;
    logic [CTX_BITS-1:0]  clr_addr_next;
    cmd_t                 cmd_reg;
    cmd_t                 cmd_next;
    row_t                 row_reg;
    row_t                 row_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_row_t             out_row_reg;
    logic                 out_acc_reg;

    logic                 ram_en;
    logic                 ram_we;
    logic [CTX_BITS-1:0]  ram_addr;
    row_t                 ram_wdata;
    logic [ROW_BITS-1:0]  ram_rdata;
    row_t                 rd_row;
    row_t                 bumped;
    row_t                 emit_row;
    logic                 load_out;
    logic                 load_ok;

    dcir_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    function automatic row_t bump_row(input row_t r, input sym_t s);
        row_t res;
        res = r;
        for (int i = 0; i < NUM_SYMS; i++)
        begin
            if (SYM_BITS'(i) == s && r[i] != {COUNT_BITS{1'b1}})
            begin
                res[i] = r[i] + 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'd65535) ? 16'hFFFF : w[OUT_BITS-1:0];
    endfunction

    assign rd_row   = ram_rdata;
    assign load_ok  = !out_valid_reg || !out_stall;
    assign clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cmd_next      = cmd_reg;
        row_next      = row_reg;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = cmd_reg.fwd_ctx[CTX_BITS-1:0];
        bumped        = bump_row(rd_row, cmd_reg.fwd_sym);
        ram_wdata     = bumped;
        q_pop         = 1'b0;
        load_out      = 1'b0;
        emit_row      = row_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_en        = 1'b1;
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    ram_en     = 1'b1;
                    ram_addr   = q_cmd.fwd_ctx[CTX_BITS-1:0];
                    state_next = ST_FWD;
                end
            end
            ST_FWD:
            begin
                if (cmd_reg.count)
                begin
                    ram_en   = 1'b1;
                    ram_we   = 1'b1;
                    row_next = bumped;
                    emit_row = bumped;
                    if (cmd_reg.inv_en)
                    begin
                        state_next = ST_INV_RD;
                    end
                    else if (load_ok)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    row_next = rd_row;
                    emit_row = rd_row;
                    if (load_ok)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_INV_RD:
            begin
                ram_en     = 1'b1;
                ram_addr   = cmd_reg.inv_ctx[CTX_BITS-1:0];
                state_next = ST_INV_WR;
            end
            ST_INV_WR:
            begin
                bumped    = bump_row(rd_row, cmd_reg.inv_sym);
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = cmd_reg.inv_ctx[CTX_BITS-1:0];
                ram_wdata = bumped;
                if (cmd_reg.inv_ctx[CTX_BITS-1:0] == cmd_reg.fwd_ctx[CTX_BITS-1:0])
                begin
                    row_next = bumped;
                    emit_row = bumped;
                end
                if (load_ok)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        row_reg <= row_next;
        if (load_out)
        begin
            for (int i = 0; i < NUM_SYMS; i++)
            begin
                out_row_reg[i] <= sat_out(emit_row[i]);
            end
            out_acc_reg <= cmd_reg.count;
        end
    end

    assign out_valid       = out_valid_reg;
    assign count_a         = out_row_reg[SYM_A];
    assign count_c         = out_row_reg[SYM_C];
    assign count_t         = out_row_reg[SYM_T];
    assign count_g         = out_row_reg[SYM_G];
    assign count_n         = out_row_reg[SYM_N];
    assign symbol_accepted = out_acc_reg;

endmodule

@@ rtl/dna_context_count_inverted_repeat.sv @@
// Top level of the order-k DNA context counter with inverted repeats.
// Ties front end, command queue and counter back end. Uses dcir_pkg,
// dcir_front, dcir_queue and dcir_back.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_stall    | opcode, symbol_byte, query_context
//  out     | out_valid / out_stall  | count_a..count_n, symbol_accepted
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each counted item does one read-modify-write on the single-port counter
// RAM in the back end; with inverted repeats on it does a second one on the
// inverted context. After reset a clearing pass writes all 2^(3*CONTEXT_SYMBOLS)
// RAM rows (4096 by default) with in_stall high; cfg writes are taken always.
// A stalled result holds in the output register while the queue keeps filling.
module dna_context_count_inverted_repeat #(
    parameter int CONTEXT_SYMBOLS = 4,
    parameter int COUNT_BITS      = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [7:0]                          symbol_byte,
    input  logic [11:0]                         query_context,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [15:0]                         count_a,
    output logic [15:0]                         count_c,
    output logic [15:0]                         count_t,
    output logic [15:0]                         count_g,
    output logic [15:0]                         count_n,
    output logic                                symbol_accepted,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcir_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic                                cfg_data
);

    import dcir_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic clearing;
    logic accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full || clearing;
    assign accept    = in_valid && !in_stall;

    dcir_front #(
        .CONTEXT_SYMBOLS (CONTEXT_SYMBOLS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .opcode        (opcode),
        .symbol_byte   (symbol_byte),
        .query_context (query_context),
        .cmd           (front_cmd)
    );

    dcir_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .cmd_in  (front_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .cmd_out (queue_cmd),
        .empty   (q_empty)
    );

    dcir_back #(
        .CONTEXT_SYMBOLS (CONTEXT_SYMBOLS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_cmd           (queue_cmd),
        .q_pop           (q_pop),
        .clearing        (clearing),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .count_a         (count_a),
        .count_c         (count_c),
        .count_t         (count_t),
        .count_g         (count_g),
        .count_n         (count_n),
        .symbol_accepted (symbol_accepted)
    );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for dna_context_count_inverted_repeat: two directed tables,
// then random DNA runs with inverted repeats on and off, then a long single-base run and more random items.
// Depends on dcir_pkg and the RTL top level only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcir_pkg::*;

    localparam int CTX_SYMS      = 4;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int PHASE_ITEMS   = 130;
    localparam int RUN_ITEMS     = 60;
    localparam int DRAIN_CYCLES  = 20;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic        op;
        logic [7:0]  sym_byte;
        logic [11:0] query;
    } stim_t;

    typedef struct packed {
        logic [15:0] cnt_a;
        logic [15:0] cnt_c;
        logic [15:0] cnt_t;
        logic [15:0] cnt_g;
        logic [15:0] cnt_n;
        logic        accepted;
    } count_res_t;

    typedef struct packed {
        stim_t      item;
        logic       typed;
        count_res_t want;
    } dir_row_t;

    localparam count_res_t NO_COUNTS = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_COUNT;
    logic [7:0]  symbol_byte = 8'h00;
    logic [11:0] query_context = 12'h000;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] count_a, count_c, count_t, count_g, count_n;
    logic        symbol_accepted;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_INV_REPEAT;
    logic        cfg_data = 1'b0;

    bit [15:0]   tally [4096][5];
    logic [11:0] hist = '0;
    logic [3:0]  skipped = '0;
    logic        inv_on = 1'b0;
    logic        skip_on = 1'b0;

    count_res_t  pending_counts [$];
    stim_t       plan_q [$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    bit          sender_gaps = 1'b1;
    int unsigned stall_pct = 0;

    dir_row_t early_rows [12] = '{
        '{'{OP_READ,  8'h00,  12'o0000}, 1'b1, NO_COUNTS},
        '{'{OP_READ,  8'hFF,  12'o7777}, 1'b1, NO_COUNTS},
        '{'{OP_COUNT, 8'h00,  12'o7777}, 1'b1, NO_COUNTS},
        '{'{OP_COUNT, 8'hFF,  12'o0000}, 1'b1, NO_COUNTS},
        '{'{OP_COUNT, 8'h61,  12'o1234}, 1'b1, NO_COUNTS},
        '{'{OP_COUNT, CHAR_A, 12'o0000}, 1'b1, '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
        '{'{OP_COUNT, CHAR_C, 12'o7777}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_T, 12'o0000}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_G, 12'o5555}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_N, 12'o2222}, 1'b0, NO_COUNTS},
        '{'{OP_READ,  CHAR_A, 12'o0123}, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b0}},
        '{'{OP_READ,  8'h80,  12'o5670}, 1'b1, NO_COUNTS}
    };

    dir_row_t late_rows [11] = '{
        '{'{OP_COUNT, CHAR_A, 12'o0000}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_G, 12'o7777}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, 8'h00,  12'o0000}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_N, 12'o0000}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_C, 12'o0000}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_A, 12'o4444}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_C, 12'o0000}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_N, 12'o0000}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_G, 12'o3333}, 1'b0, NO_COUNTS},
        '{'{OP_COUNT, CHAR_T, 12'o0000}, 1'b1, '{16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 1'b1}},
        '{'{OP_READ,  8'h54,  12'o0143}, 1'b1, '{16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 1'b0}}
    };

    dna_context_count_inverted_repeat #(
        .CONTEXT_SYMBOLS(CTX_SYMS),
        .COUNT_BITS(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .symbol_byte(symbol_byte),
        .query_context(query_context),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .count_a(count_a),
        .count_c(count_c),
        .count_t(count_t),
        .count_g(count_g),
        .count_n(count_n),
        .symbol_accepted(symbol_accepted),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic sym_t mirror_base(input sym_t s);
        case (s)
            SYM_A:   return SYM_T;
            SYM_C:   return SYM_G;
            SYM_T:   return SYM_A;
            SYM_G:   return SYM_C;
            default: return s;
        endcase
    endfunction

    function automatic logic [7:0] base_char(input sym_t s);
        case (s)
            SYM_A:   return CHAR_A;
            SYM_C:   return CHAR_C;
            SYM_T:   return CHAR_T;
            SYM_G:   return CHAR_G;
            default: return CHAR_N;
        endcase
    endfunction

    function automatic count_res_t tally_row(input logic [11:0] ctx, input logic acc);
        count_res_t r;
        r.cnt_a = tally[ctx][0];
        r.cnt_c = tally[ctx][1];
        r.cnt_t = tally[ctx][2];
        r.cnt_g = tally[ctx][3];
        r.cnt_n = tally[ctx][4];
        r.accepted = acc;
        return r;
    endfunction

    function automatic void bump_tally(input logic [11:0] ctx, input sym_t s);
        if (tally[ctx][s] != 16'hFFFF)
            tally[ctx][s] = tally[ctx][s] + 16'd1;
    endfunction

    function automatic count_res_t predict_counts(input stim_t s);
        logic [11:0] ctx;
        logic [11:0] inv_ctx;
        sym_t        code;
        logic        known;
        count_res_t  r;
        ctx = hist;
        if (s.op == OP_READ)
            return tally_row(s.query, 1'b0);
        if (skip_on && skipped < 4'(CTX_SYMS))
        begin
            skipped = skipped + 4'd1;
            return tally_row(ctx, 1'b0);
        end
        known = 1'b1;
        code = SYM_A;
        case (s.sym_byte)
            CHAR_A:  code = SYM_A;
            CHAR_C:  code = SYM_C;
            CHAR_T:  code = SYM_T;
            CHAR_G:  code = SYM_G;
            CHAR_N:  code = SYM_N;
            default: known = 1'b0;
        endcase
        if (!known)
            return tally_row(ctx, 1'b0);
        bump_tally(ctx, code);
        if (inv_on)
        begin
            inv_ctx = {mirror_base(code), mirror_base(ctx[2:0]),
                       mirror_base(ctx[5:3]), mirror_base(ctx[8:6])};
            bump_tally(inv_ctx, mirror_base(ctx[11:9]));
        end
        r = tally_row(ctx, 1'b1);
        hist = {ctx[8:0], code};
        return r;
    endfunction

    task automatic send_item(input stim_t s, input logic typed, input count_res_t typed_res);
        count_res_t got;
        if (burst_left == 0)
        begin
            if (sender_gaps)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
            begin
                burst_left = 1000;
            end
        end
        in_valid      <= 1'b1;
        opcode        <= s.op;
        symbol_byte   <= s.sym_byte;
        query_context <= s.query;
        do @(posedge clk); while (in_stall);
        burst_left--;
        got = predict_counts(s);
        pending_counts.push_back(typed ? typed_res : got);
    endtask

    task automatic drain_counts();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_counts.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_INV_REPEAT:   inv_on = val;
            CFG_SKIP_LEADING: skip_on = val;
            default: ;
        endcase
    endtask

    task automatic plan_random();
        stim_t s;
        sym_t  run_syms [6];
        int    n;
        int    pick;
        s.op = OP_COUNT;
        s.sym_byte = 8'($urandom);
        s.query = 12'($urandom);
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            s.op = OP_READ;
            if ($urandom_range(1)) s.query = hist;
            plan_q.push_back(s);
        end
        else if (pick < 27)
        begin
            plan_q.push_back(s);
        end
        else if (pick < 50)
        begin
            // run of bases followed by its reverse complement
            n = $urandom_range(2, 6);
            for (int i = 0; i < n; i++)
            begin
                run_syms[i] = sym_t'($urandom_range(4));
                s.sym_byte = base_char(run_syms[i]);
                s.query = 12'($urandom);
                plan_q.push_back(s);
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                s.sym_byte = base_char(mirror_base(run_syms[i]));
                s.query = 12'($urandom);
                plan_q.push_back(s);
            end
        end
        else
        begin
            s.sym_byte = base_char(sym_t'($urandom_range(4)));
            plan_q.push_back(s);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        count_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("unexpected result with nothing pending");
                mismatches++;
            end
            else
            begin
                want = pending_counts.pop_front();
                check_field("count_a", want.cnt_a, count_a);
                check_field("count_c", want.cnt_c, count_c);
                check_field("count_t", want.cnt_t, count_t);
                check_field("count_g", want.cnt_g, count_g);
                check_field("count_n", want.cnt_n, count_n);
                check_field("symbol_accepted", want.accepted, symbol_accepted);
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        stim_t s;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (early_rows[i])
            send_item(early_rows[i].item, early_rows[i].typed, early_rows[i].want);
        drain_counts();

        write_reg(CFG_INV_REPEAT, 1'b1);
        write_reg(CFG_SKIP_LEADING, 1'b1);
        write_reg(CFG_SPARE_LO, 1'b1);
        write_reg(CFG_SPARE_HI, 1'b0);
        cfg_valid <= 1'b0;
        stall_pct = 25;
        foreach (late_rows[i])
            send_item(late_rows[i].item, late_rows[i].typed, late_rows[i].want);
        drain_counts();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_INV_REPEAT, ph[0]);
            write_reg(CFG_SKIP_LEADING, ph[1]);
            cfg_valid <= 1'b0;
            sender_gaps = (ph % 3 != 1);
            stall_pct = (ph * 30) % 100;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (plan_q.size() == 0) plan_random();
                send_item(plan_q.pop_front(), 1'b0, NO_COUNTS);
            end
            drain_counts();
        end

        // long all-A run on the forward and inverted counters
        write_reg(CFG_INV_REPEAT, 1'b1);
        cfg_valid <= 1'b0;
        sender_gaps = 1'b0;
        stall_pct = 0;
        s.op = OP_COUNT;
        s.sym_byte = CHAR_A;
        for (int k = 0; k < RUN_ITEMS; k++)
        begin
            s.query = 12'($urandom);
            send_item(s, 1'b0, NO_COUNTS);
        end
        s.op = OP_READ;
        s.query = 12'o0000;
        send_item(s, 1'b0, NO_COUNTS);
        s.query = 12'o2222;
        send_item(s, 1'b0, NO_COUNTS);
        sender_gaps = 1'b1;
        stall_pct = 40;
        for (int k = 0; k < 40; k++)
        begin
            if (plan_q.size() == 0) plan_random();
            send_item(plan_q.pop_front(), 1'b0, NO_COUNTS);
        end
        drain_counts();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/dcir_pkg.sv
rtl/dcir_ram.sv
rtl/dcir_front.sv
rtl/dcir_queue.sv
rtl/dcir_back.sv
rtl/dna_context_count_inverted_repeat.sv
dv/tb.sv
